// ===== design/wfe_pkg.sv =====
// Shared types, register indexes and the CRC-8 byte update for the WAKE frame encoder.
// Used by wfe_cfg_regs and wake_frame_encoder. No dependencies.
`timescale 1ns / 1ps

package wfe_pkg;

    // Configuration register indexes
    localparam logic [3:0] CFG_FRAME_END       = 4'd0;
    localparam logic [3:0] CFG_ESCAPE          = 4'd1;
    localparam logic [3:0] CFG_ESCAPED_END     = 4'd2;
    localparam logic [3:0] CFG_ESCAPED_ESCAPE  = 4'd3;
    localparam int unsigned CFG_INDEX_W        = 4;

    // Reset values of the escape codes
    localparam logic [7:0] RST_FRAME_END       = 8'hC0;
    localparam logic [7:0] RST_ESCAPE          = 8'hDB;
    localparam logic [7:0] RST_ESCAPED_END     = 8'hDC;
    localparam logic [7:0] RST_ESCAPED_ESCAPE  = 8'hDD;

    // CRC-8 constants
    localparam logic [7:0] CRC_INIT            = 8'hFF;
    localparam logic [7:0] CRC_POLY            = 8'h31;

    // Input item kinds carried on tuser
    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Current escape code set
    typedef struct packed {
        logic [7:0] frame_end;
        logic [7:0] escape;
        logic [7:0] escaped_end;
        logic [7:0] escaped_escape;
    } t_codes;

    // One byte through the MSB-first CRC-8 with polynomial 0x31.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/wfe_cfg_regs.sv =====
// Escape code register file of the WAKE frame encoder.
// Depends on wfe_pkg for the register indexes, reset values and t_codes.
`timescale 1ns / 1ps

module wfe_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [wfe_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [7:0]                         i_cfg_data,
    output wfe_pkg::t_codes                    o_codes
);
    import wfe_pkg::*;

    t_codes r_codes;

    // Writes to an index outside the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.frame_end      <= RST_FRAME_END;
            r_codes.escape         <= RST_ESCAPE;
            r_codes.escaped_end    <= RST_ESCAPED_END;
            r_codes.escaped_escape <= RST_ESCAPED_ESCAPE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_END:      r_codes.frame_end      <= i_cfg_data;
                CFG_ESCAPE:         r_codes.escape         <= i_cfg_data;
                CFG_ESCAPED_END:    r_codes.escaped_end    <= i_cfg_data;
                CFG_ESCAPED_ESCAPE: r_codes.escaped_escape <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_codes = r_codes;

endmodule

// ===== design/wake_frame_encoder.sv =====
// Top level of the WAKE frame encoder: item register, byte sequencer, stuffing and CRC-8.
// Depends on wfe_pkg and wfe_cfg_regs.
`timescale 1ns / 1ps

// Usage:
// The slave stream takes items: tuser[0] is the kind (0 header, 1 payload byte),
// tdata carries address, command, length and payload. A header opens a frame and
// sends the marker byte, the stuffed address, command and length, and the stuffed
// CRC-8 at once when length is 0. Each payload byte goes out stuffed; after the
// last declared one the stuffed CRC closes the frame (tuser[0] high on its last
// beat). A payload item with no frame open gives one beat with tuser[1] set and
// tdata zero. tlast marks the last beat caused by each item.
// An accepted item is held in the item register; its first beat then moves into the
// output register once that can take it, and is offered on the master side from there.
// Throughput: one wire byte per cycle while the master side is ready, set by the output
// byte register. An item makes 1 or 2 beats for a payload byte without the
// CRC, up to 4 with it, 4 to 9 for a header. The next item is taken in the cycle
// the last beat of the current one moves into the output register.
// A stalled master side holds its beat; the sequencer waits with it.
// Synchronous reset restores the default WAKE codes, closes any frame and empties
// the item and output registers. The config port is always ready; write it only
// while the block is idle.
module wake_frame_encoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Slave stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [31:0]                        i_s_tdata,   // address, command, length, payload
    input  logic [0:0]                         i_s_tuser,   // op
    // Master stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [7:0]                         o_m_tdata,   // out_byte
    output logic [1:0]                         o_m_tuser,   // frame_end, error
    output logic                               o_m_tlast,   // run_last
    // Configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [wfe_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [7:0]                         i_cfg_data
);
    import wfe_pkg::*;

    typedef enum logic [2:0] {
        SEQ_MARK,
        SEQ_ADDR,
        SEQ_CMD,
        SEQ_LEN,
        SEQ_DATA,
        SEQ_CRC
    } t_seq;

    t_codes     w_codes;

    // Item register and sequencer state
    logic       r_busy,  n_busy;
    t_seq       r_seq,   n_seq;
    logic       r_half,  n_half;
    logic [7:0] r_addr,  n_addr;
    logic [7:0] r_cmd,   n_cmd;
    logic [7:0] r_len,   n_len;
    logic [7:0] r_pay,   n_pay;
    // Frame state
    logic [7:0] r_crc,   n_crc;
    logic [7:0] r_left,  n_left;
    logic       r_open,  n_open;
    // Output register
    logic       r_ov,    n_ov;
    logic [7:0] r_obyte, n_obyte;
    logic       r_ofe,   n_ofe;
    logic       r_olast, n_olast;
    logic       r_oerr,  n_oerr;

    logic       w_adv;
    logic       w_work;
    logic [7:0] w_raw;
    logic       w_err;
    logic       w_stuff;
    logic       w_done;
    logic       w_last_raw;
    logic [7:0] w_beat;
    logic [7:0] w_crc_in;
    logic [7:0] w_crc_next;
    logic       w_take;

    wfe_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_codes     (w_codes)
    );

    assign o_cfg_ready = 1'b1;

    // The output register can take a beat when empty or being drained.
    assign w_adv  = !r_ov || i_m_tready;
    assign w_work = r_busy && w_adv;

    // Raw byte of the current sequence step.
    always_comb begin
        unique case (r_seq)
            SEQ_MARK: w_raw = w_codes.frame_end;
            SEQ_ADDR: w_raw = r_addr;
            SEQ_CMD:  w_raw = r_cmd;
            SEQ_LEN:  w_raw = r_len;
            SEQ_DATA: w_raw = r_pay;
            SEQ_CRC:  w_raw = r_crc;
            default:  w_raw = 8'h00;
        endcase
    end

    // Stuffing: the marker goes out plain, an error beat is zero, and a byte equal
    // to a marker or escape code takes two beats.
    assign w_err   = (r_seq == SEQ_DATA) && !r_open;
    assign w_stuff = (r_seq != SEQ_MARK) && !w_err &&
                     ((w_raw == w_codes.frame_end) || (w_raw == w_codes.escape));
    assign w_done  = !w_stuff || r_half;

    always_comb begin
        if (w_err) begin
            w_beat = 8'h00;
        end else if (w_stuff && !r_half) begin
            w_beat = w_codes.escape;
        end else if (w_stuff) begin
            w_beat = (w_raw == w_codes.frame_end) ? w_codes.escaped_end
                                                  : w_codes.escaped_escape;
        end else begin
            w_beat = w_raw;
        end
    end

    // Whether this raw byte is the last one caused by the item.
    always_comb begin
        unique case (r_seq)
            SEQ_MARK, SEQ_ADDR, SEQ_CMD: w_last_raw = 1'b0;
            SEQ_LEN:  w_last_raw = (r_len != 8'h00);
            SEQ_DATA: w_last_raw = w_err || (r_left != 8'h01);
            SEQ_CRC:  w_last_raw = 1'b1;
            default:  w_last_raw = 1'b1;
        endcase
    end

    // CRC runs over unstuffed bytes; a header restarts it from the initial value.
    assign w_crc_in   = (r_seq == SEQ_MARK) ? CRC_INIT : r_crc;
    assign w_crc_next = crc8_byte(w_crc_in, w_raw);

    assign o_s_tready = !r_busy || (w_work && w_done && w_last_raw);
    assign w_take     = i_s_tvalid && o_s_tready;

    // Next state of sequencer, frame state and output register
    always_comb begin
        n_busy  = r_busy;
        n_seq   = r_seq;
        n_half  = r_half;
        n_addr  = r_addr;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_pay   = r_pay;
        n_crc   = r_crc;
        n_left  = r_left;
        n_open  = r_open;
        n_ov    = r_ov;
        n_obyte = r_obyte;
        n_ofe   = r_ofe;
        n_olast = r_olast;
        n_oerr  = r_oerr;

        if (w_work) begin
            n_half = w_stuff && !r_half;
            if (w_done) begin
                unique case (r_seq)
                    SEQ_MARK: begin
                        n_crc = w_crc_next;
                        n_seq = SEQ_ADDR;
                    end
                    SEQ_ADDR: begin
                        n_crc = w_crc_next;
                        n_seq = SEQ_CMD;
                    end
                    SEQ_CMD: begin
                        n_crc = w_crc_next;
                        n_seq = SEQ_LEN;
                    end
                    SEQ_LEN: begin
                        n_crc  = w_crc_next;
                        n_left = r_len;
                        n_open = 1'b1;
                        n_seq  = SEQ_CRC;
                    end
                    SEQ_DATA: begin
                        if (!w_err) begin
                            n_crc  = w_crc_next;
                            n_left = r_left - 8'h01;
                        end
                        n_seq = SEQ_CRC;
                    end
                    SEQ_CRC: begin
                        n_crc  = CRC_INIT;
                        n_left = 8'h00;
                        n_open = 1'b0;
                    end
                    default: ;
                endcase
                if (w_last_raw) begin
                    n_busy = 1'b0;
                end
            end
        end

        if (w_adv) begin
            n_ov = r_busy;
            if (r_busy) begin
                n_obyte = w_beat;
                n_ofe   = (r_seq == SEQ_CRC) && w_done;
                n_olast = w_done && w_last_raw;
                n_oerr  = w_err;
            end
        end

        if (w_take) begin
            n_busy = 1'b1;
            n_half = 1'b0;
            n_seq  = (i_s_tuser[0] == OP_PAYLOAD) ? SEQ_DATA : SEQ_MARK;
            n_addr = i_s_tdata[7:0];
            n_cmd  = i_s_tdata[15:8];
            n_len  = i_s_tdata[23:16];
            n_pay  = i_s_tdata[31:24];
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_seq  <= SEQ_MARK;
            r_half <= 1'b0;
            r_crc  <= CRC_INIT;
            r_left <= 8'h00;
            r_open <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_seq  <= n_seq;
            r_half <= n_half;
            r_crc  <= n_crc;
            r_left <= n_left;
            r_open <= n_open;
            r_ov   <= n_ov;
        end
        r_addr  <= n_addr;
        r_cmd   <= n_cmd;
        r_len   <= n_len;
        r_pay   <= n_pay;
        r_obyte <= n_obyte;
        r_ofe   <= n_ofe;
        r_olast <= n_olast;
        r_oerr  <= n_oerr;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_obyte;
    assign o_m_tuser  = {r_oerr, r_ofe};
    assign o_m_tlast  = r_olast;

endmodule

// ===== design/wfe_checker.sv =====
// Port-level checks of the WAKE frame encoder and the bind that attaches them.
// Depends on wake_frame_encoder's port list only.
`timescale 1ns / 1ps

module wfe_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        o_s_tready,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  o_m_tdata,
    input  logic [1:0]  o_m_tuser,
    input  logic        o_m_tlast
);

    // The CRC beat that closes a frame is always the last beat of its item.
    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> o_m_tlast)
        else $error("frame end beat without tlast");

    // An error beat stands alone, carries a zero byte and never closes a frame.
    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (o_m_tlast && (o_m_tdata == 8'h00) && !o_m_tuser[0]))
        else $error("malformed error beat");

    // A stalled beat holds its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("master beat changed while stalled");

    // Once a new item is taken, the block shows a beat on its master side.
    a_item_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> ##1 o_m_tvalid)
        else $error("accepted item produced no beat");

endmodule

bind wake_frame_encoder wfe_checker u_wfe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// ===== tb/wake_frame_encoder_checker.sv =====
// Checker for the WAKE frame encoder: watches the item, result and config channels,
// predicts the stuffed wire bytes with their own CRC-8, and counts mismatches.
// Depends on wfe_pkg for the register indexes, reset codes and item kinds.
`timescale 1ns / 1ps

module wake_frame_encoder_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Item stream as seen at the block's slave side
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [31:0]                     i_s_tdata,   // address, command, length, payload
    input  logic [0:0]                      i_s_tuser,   // op
    // Result stream as seen at the block's master side
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [7:0]                      i_m_tdata,   // out_byte
    input  logic [1:0]                      i_m_tuser,   // frame_end, error
    input  logic                            i_m_tlast,   // run_last
    // Register writes
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [wfe_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]                      i_cfg_data,
    // Status toward the testbench top
    output int                              o_mismatches,
    output int                              o_outstanding
);

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       frame_end;
        logic       run_last;
        logic       error;
    } t_beat;

    // Wire beats still to come, oldest first.
    t_beat           pending_beats[$];

    // Beats produced by the item being encoded.
    t_beat           item_beats[9];
    int              item_cnt;

    // Encoder state and the register copy.
    wfe_pkg::t_codes codes;
    logic [7:0]      crc_run;
    logic [7:0]      bytes_due;
    logic            in_frame;
    int              n_bad;

    // MSB-first CRC-8, one byte folded in.
    function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = acc ^ data;
        repeat (8) begin
            r = r[7] ? ((r << 1) ^ wfe_pkg::CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    task automatic add_beat(input logic [7:0] b, input logic fe, input logic err);
        item_beats[item_cnt] = '{wire_byte: b, frame_end: fe, run_last: 1'b0, error: err};
        item_cnt++;
    endtask

    // A marker match wins over an escape match when both codes are equal.
    task automatic add_stuffed(input logic [7:0] b, input logic fe);
        if (b == codes.frame_end) begin
            add_beat(codes.escape, 1'b0, 1'b0);
            add_beat(codes.escaped_end, fe, 1'b0);
        end else if (b == codes.escape) begin
            add_beat(codes.escape, 1'b0, 1'b0);
            add_beat(codes.escaped_escape, fe, 1'b0);
        end else begin
            add_beat(b, fe, 1'b0);
        end
    endtask

    task automatic close_frame();
        add_stuffed(crc_run, 1'b1);
        in_frame  = 1'b0;
        crc_run   = wfe_pkg::CRC_INIT;
        bytes_due = 8'd0;
    endtask

    // Works out every wire beat one accepted item causes and queues them.
    task automatic encode_item(input logic op, input logic [7:0] addr, input logic [7:0] cmd,
                               input logic [7:0] len, input logic [7:0] pay);
        item_cnt = 0;
        if (op == wfe_pkg::OP_HEADER) begin
            // A header always restarts the CRC, abandoning any open frame.
            crc_run   = crc_fold(wfe_pkg::CRC_INIT, codes.frame_end);
            crc_run   = crc_fold(crc_run, addr);
            crc_run   = crc_fold(crc_run, cmd);
            crc_run   = crc_fold(crc_run, len);
            bytes_due = len;
            in_frame  = 1'b1;
            add_beat(codes.frame_end, 1'b0, 1'b0);
            add_stuffed(addr, 1'b0);
            add_stuffed(cmd, 1'b0);
            add_stuffed(len, 1'b0);
            if (len == 8'd0) begin
                close_frame();
            end
        end else if (!in_frame) begin
            add_beat(8'd0, 1'b0, 1'b1);
        end else begin
            crc_run = crc_fold(crc_run, pay);
            add_stuffed(pay, 1'b0);
            bytes_due = bytes_due - 8'd1;
            if (bytes_due == 8'd0) begin
                close_frame();
            end
        end
        item_beats[item_cnt - 1].run_last = 1'b1;
        for (int i = 0; i < item_cnt; i++) begin
            pending_beats.push_back(item_beats[i]);
        end
    endtask

    // Compare results first so that a beat never meets an expectation of the
    // item accepted on the same edge, then apply writes, then predict.
    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (!i_rst_n) begin
            codes     = '{wfe_pkg::RST_FRAME_END, wfe_pkg::RST_ESCAPE,
                          wfe_pkg::RST_ESCAPED_END, wfe_pkg::RST_ESCAPED_ESCAPE};
            crc_run   = wfe_pkg::CRC_INIT;
            bytes_due = 8'd0;
            in_frame  = 1'b0;
            n_bad     = 0;
            pending_beats.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = '{wire_byte: i_m_tdata, frame_end: i_m_tuser[0],
                        run_last: i_m_tlast, error: i_m_tuser[1]};
                if (pending_beats.size() == 0) begin
                    $error("unexpected beat: out_byte %02h frame_end %0b run_last %0b error %0b",
                           got.wire_byte, got.frame_end, got.run_last, got.error);
                    n_bad++;
                end else begin
                    want = pending_beats.pop_front();
                    if (got.wire_byte != want.wire_byte) begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.wire_byte, got.wire_byte);
                        n_bad++;
                    end
                    if (got.frame_end != want.frame_end) begin
                        $error("frame_end mismatch: expected %0b, actual %0b",
                               want.frame_end, got.frame_end);
                        n_bad++;
                    end
                    if (got.run_last != want.run_last) begin
                        $error("run_last mismatch: expected %0b, actual %0b",
                               want.run_last, got.run_last);
                        n_bad++;
                    end
                    if (got.error != want.error) begin
                        $error("error mismatch: expected %0b, actual %0b",
                               want.error, got.error);
                        n_bad++;
                    end
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    wfe_pkg::CFG_FRAME_END:      codes.frame_end      = i_cfg_data;
                    wfe_pkg::CFG_ESCAPE:         codes.escape         = i_cfg_data;
                    wfe_pkg::CFG_ESCAPED_END:    codes.escaped_end    = i_cfg_data;
                    wfe_pkg::CFG_ESCAPED_ESCAPE: codes.escaped_escape = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_s_tvalid && i_s_tready) begin
                encode_item(i_s_tuser[0], i_s_tdata[7:0], i_s_tdata[15:8],
                            i_s_tdata[23:16], i_s_tdata[31:24]);
            end
        end
        o_mismatches  <= n_bad;
        o_outstanding <= pending_beats.size();
    end

endmodule

// ===== tb/wake_frame_encoder_tb.sv =====
// Testbench top for the WAKE frame encoder: clock, reset, item and register stimulus
// with random idling, and the final verdict. Depends on wfe_pkg, wake_frame_encoder
// and wake_frame_encoder_checker.
`timescale 1ns / 1ps

module wake_frame_encoder_tb;

    localparam int CYCLE_LIMIT = 300000;

    // Register indexes that map to nothing.
    localparam logic [wfe_pkg::CFG_INDEX_W-1:0] UNMAPPED_LOW = 4'd4;
    localparam logic [wfe_pkg::CFG_INDEX_W-1:0] UNMAPPED_MID = 4'd8;
    localparam logic [wfe_pkg::CFG_INDEX_W-1:0] UNMAPPED_TOP = 4'd15;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [31:0]                     s_tdata;
    logic [0:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [7:0]                      m_tdata;
    logic [1:0]                      m_tuser;
    logic                            m_tlast;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [wfe_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]                      cfg_data;

    int                              mismatches;
    int                              outstanding;
    int                              cycles = 0;
    bit                              calm;
    logic [7:0]                      code_copy[4];

    wake_frame_encoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    wake_frame_encoder_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog against a hung handshake.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result-side back-pressure: random stall bursts, none in the calm part.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Byte for stimulus, leaning toward the codes that need stuffing.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return code_copy[wfe_pkg::CFG_FRAME_END[1:0]];
            1:       return code_copy[wfe_pkg::CFG_ESCAPE[1:0]];
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offers one item, maybe after an idle burst, and returns on the accepting edge.
    task automatic send_item(input logic op, input logic [7:0] addr, input logic [7:0] cmd,
                             input logic [7:0] len, input logic [7:0] pay);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pay, len, cmd, addr};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_header(input logic [7:0] addr, input logic [7:0] cmd,
                               input logic [7:0] len);
        send_item(wfe_pkg::OP_HEADER, addr, cmd, len, 8'($urandom));
    endtask

    task automatic send_payload(input logic [7:0] pay);
        send_item(wfe_pkg::OP_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom), pay);
    endtask

    // Drops valid and waits until every expected beat has come out.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [wfe_pkg::CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx <= wfe_pkg::CFG_ESCAPED_ESCAPE) begin
            code_copy[idx[1:0]] = val;
        end
    endtask

    task automatic write_codes(input logic [7:0] fe, input logic [7:0] esc,
                               input logic [7:0] esc_fe, input logic [7:0] esc_esc);
        write_reg(wfe_pkg::CFG_FRAME_END, fe);
        write_reg(wfe_pkg::CFG_ESCAPE, esc);
        write_reg(wfe_pkg::CFG_ESCAPED_END, esc_fe);
        write_reg(wfe_pkg::CFG_ESCAPED_ESCAPE, esc_esc);
    endtask

    initial begin
        int          sent;
        int          pick;
        int          count;
        logic [7:0]  len;
        logic [7:0]  shared;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm      = 1'b0;
        code_copy[wfe_pkg::CFG_FRAME_END[1:0]]      = wfe_pkg::RST_FRAME_END;
        code_copy[wfe_pkg::CFG_ESCAPE[1:0]]         = wfe_pkg::RST_ESCAPE;
        code_copy[wfe_pkg::CFG_ESCAPED_END[1:0]]    = wfe_pkg::RST_ESCAPED_END;
        code_copy[wfe_pkg::CFG_ESCAPED_ESCAPE[1:0]] = wfe_pkg::RST_ESCAPED_ESCAPE;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed part with the reset codes.
        send_header(8'h00, 8'hFF, 8'h00);          // empty frame, CRC right away
        send_payload(8'h5A);                       // no frame open
        send_header(8'hC0, 8'hDB, 8'h02);          // address and command need stuffing
        send_payload(8'hC0);
        send_payload(8'hDB);
        send_header(8'hDB, 8'hC0, 8'hC0);          // stuffed length, frame abandoned
        send_payload(8'h00);
        send_header(8'hFF, 8'h00, 8'hFF);          // longest length, abandoned too
        send_payload(8'hFF);
        send_header(8'h12, 8'h34, 8'h01);
        send_payload(8'hFF);
        send_payload(8'h00);                       // frame just closed
        send_header(8'($urandom), 8'($urandom), 8'h03);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'h80);
        settle();

        // Marker and escape equal, plus writes to unmapped indexes.
        write_codes(8'h55, 8'h55, 8'hAA, 8'h00);
        write_reg(UNMAPPED_LOW, 8'hFF);
        write_reg(UNMAPPED_MID, 8'h00);
        write_reg(UNMAPPED_TOP, 8'hA5);
        send_header(8'h55, 8'hAA, 8'h01);
        send_payload(8'h55);
        send_header(8'h00, 8'h55, 8'h00);

        // Random part, one code setting per phase; the last phase runs without idling.
        for (int phase = 0; phase < 5; phase++) begin
            settle();
            case (phase)
                0: write_codes(wfe_pkg::RST_FRAME_END, wfe_pkg::RST_ESCAPE,
                               wfe_pkg::RST_ESCAPED_END, wfe_pkg::RST_ESCAPED_ESCAPE);
                1: write_codes(8'hFF, 8'h00, 8'hFF, 8'h00);
                2: begin
                    shared = 8'($urandom);
                    write_codes(shared, shared, 8'($urandom), 8'($urandom));
                end
                3: write_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                default: write_codes(wfe_pkg::RST_FRAME_END, wfe_pkg::RST_ESCAPE,
                                     wfe_pkg::RST_ESCAPED_END, wfe_pkg::RST_ESCAPED_ESCAPE);
            endcase
            calm = (phase == 4);
            sent = 0;
            while (sent < 70) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    // Stray payload byte, mostly with no frame open.
                    send_payload(pick_byte());
                    sent++;
                end else begin
                    len = (pick < 18) ? 8'($urandom) : 8'($urandom_range(0, 6));
                    if (pick < 12 && $urandom_range(0, 1) == 0) begin
                        len = pick_byte();
                    end
                    // Long frames and some short ones are cut off by the next header.
                    if (len > 8'd12) begin
                        count = $urandom_range(0, 4);
                    end else if (pick < 28) begin
                        count = $urandom_range(0, len);
                    end else begin
                        count = len;
                    end
                    send_header(pick_byte(), pick_byte(), len);
                    for (int i = 0; i < count; i++) begin
                        send_payload(pick_byte());
                    end
                    sent += 1 + count;
                end
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== wake_frame_encoder.f =====
design/wfe_pkg.sv
design/wfe_cfg_regs.sv
design/wake_frame_encoder.sv
design/wfe_checker.sv
tb/wake_frame_encoder_checker.sv
tb/wake_frame_encoder_tb.sv
